>>> rtl/line_triangle_plucker_test_macros.svh
// Assertion macros shared by the block's checking code.
`ifndef LINE_TRIANGLE_PLUCKER_TEST_MACROS_SVH
`define LINE_TRIANGLE_PLUCKER_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plt check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plt check failed");

`endif

>>> rtl/plt_pkg.sv
package plt_pkg;

   localparam int DefaultCoordWidth = 16;
   localparam int CsrIndexWidth     = 2;
   localparam int HitClassWidth     = 3;
   localparam int NumStages         = 6;
   localparam int NumSides          = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      VERTEX_ZERO_IDX = 2'd0,
      VERTEX_ONE_IDX  = 2'd1,
      VERTEX_TWO_IDX  = 2'd2
   } csr_index_type;

   typedef enum logic [HitClassWidth-1:0] {
      HIT_NONE     = 3'd0,
      HIT_COPLANAR = 3'd1,
      HIT_INTERIOR = 3'd2,
      HIT_EDGE     = 3'd3,
      HIT_VERTEX   = 3'd4
   } hit_class_type;

   typedef struct packed {
      logic [NumStages-1:0] stage_valid;
      logic                 in_ready;
   } pipe_status_type;

   function automatic hit_class_type classify(input logic [NumSides-1:0] zero,
                                              input logic [NumSides-1:0] neg);
      logic [NumSides-1:0] pos;
      logic [1:0]          n_zero;
      logic [1:0]          n_pos;
      logic [1:0]          n_neg;
      hit_class_type       cls;
      pos    = ~zero & ~neg;
      n_zero = 2'(zero[0]) + 2'(zero[1]) + 2'(zero[2]);
      n_pos  = 2'(pos[0]) + 2'(pos[1]) + 2'(pos[2]);
      n_neg  = 2'(neg[0]) + 2'(neg[1]) + 2'(neg[2]);
      priority if (&zero) begin
         cls = HIT_COPLANAR;
      end else if ((&pos) || (&neg)) begin
         cls = HIT_INTERIOR;
      end else if (n_zero == 2'd1 && (n_pos == 2'd2 || n_neg == 2'd2)) begin
         cls = HIT_EDGE;
      end else if (n_zero == 2'd2) begin
         cls = HIT_VERTEX;
      end else begin
         cls = HIT_NONE;
      end
      return cls;
   endfunction

endpackage

>>> rtl/plt_edge_coords.sv
module plt_edge_coords
   import plt_pkg::*;
#(
   parameter int COORD_WIDTH = DefaultCoordWidth
) (
   input  logic                                    clock,
   input  logic [3*COORD_WIDTH-1:0]                vertex_a,
   input  logic [3*COORD_WIDTH-1:0]                vertex_b,
   output logic signed [2*COORD_WIDTH:0]           prod_coord [3],
   output logic signed [COORD_WIDTH:0]             diff_coord [3]
);

   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] a [3];
   logic signed [COORD_WIDTH-1:0] b [3];
   logic signed [PW-1:0]          prod_in [3];
   logic signed [DW-1:0]          diff_in [3];
   logic signed [PW-1:0]          prod_ff [3];
   logic signed [DW-1:0]          diff_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a[i] = vertex_a[i*COORD_WIDTH +: COORD_WIDTH];
         b[i] = vertex_b[i*COORD_WIDTH +: COORD_WIDTH];
      end
      prod_in[0] = PW'(a[0]) * PW'(b[1]) - PW'(b[0]) * PW'(a[1]);
      prod_in[1] = PW'(a[0]) * PW'(b[2]) - PW'(b[0]) * PW'(a[2]);
      prod_in[2] = PW'(a[1]) * PW'(b[2]) - PW'(b[1]) * PW'(a[2]);
      diff_in[0] = DW'(a[0]) - DW'(b[0]);
      diff_in[1] = DW'(a[2]) - DW'(b[2]);
      diff_in[2] = DW'(b[1]) - DW'(a[1]);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      diff_ff <= diff_in;
   end

   assign prod_coord = prod_ff;
   assign diff_coord = diff_ff;

endmodule

>>> rtl/plt_side_pipe.sv
module plt_side_pipe
   import plt_pkg::*;
#(
   parameter int COORD_WIDTH = DefaultCoordWidth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [COORD_WIDTH-1:0]     in_start [3],
   input  logic signed [COORD_WIDTH-1:0]     in_end [3],
   input  logic signed [2*COORD_WIDTH:0]     edge_prod [NumSides][3],
   input  logic signed [COORD_WIDTH:0]       edge_diff [NumSides][3],
   input  logic                              out_ready,
   output logic                              out_valid,
   output hit_class_type                     out_class,
   output pipe_status_type                   status
);

   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH + 1;
   localparam int MW = PW + DW;
   localparam int SW = MW + 3;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages:0]   ready;

   logic signed [COORD_WIDTH-1:0] p0_ff [3];
   logic signed [COORD_WIDTH-1:0] p1_ff [3];
   logic signed [PW-1:0]          lp_ff [3];
   logic signed [DW-1:0]          ld_ff [3];
   logic signed [PW-1:0]          lp_in [3];
   logic signed [DW-1:0]          ld_in [3];
   logic signed [MW-1:0]          term_ff [NumSides][6];
   logic signed [MW-1:0]          term_in [NumSides][6];
   logic signed [MW:0]            pair_ff [NumSides][3];
   logic signed [MW:0]            pair_in [NumSides][3];
   logic signed [SW-1:0]          sum_in [NumSides];
   logic [NumSides-1:0]           zero_ff;
   logic [NumSides-1:0]           neg_ff;
   logic [NumSides-1:0]           zero_in;
   logic [NumSides-1:0]           neg_in;
   hit_class_type                 class_ff;

   always_comb begin
      ready[NumStages] = out_ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      if (ready[0]) begin
         valid_in[0] = in_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < NumStages; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      lp_in[0] = PW'(p0_ff[0]) * PW'(p1_ff[1]) - PW'(p1_ff[0]) * PW'(p0_ff[1]);
      lp_in[1] = PW'(p0_ff[0]) * PW'(p1_ff[2]) - PW'(p1_ff[0]) * PW'(p0_ff[2]);
      lp_in[2] = PW'(p0_ff[1]) * PW'(p1_ff[2]) - PW'(p1_ff[1]) * PW'(p0_ff[2]);
      ld_in[0] = DW'(p0_ff[0]) - DW'(p1_ff[0]);
      ld_in[1] = DW'(p0_ff[2]) - DW'(p1_ff[2]);
      ld_in[2] = DW'(p1_ff[1]) - DW'(p0_ff[1]);
      for (int s = 0; s < NumSides; s++) begin
         term_in[s][0] = MW'(lp_ff[0]) * MW'(edge_diff[s][1]);
         term_in[s][1] = MW'(lp_ff[1]) * MW'(edge_diff[s][2]);
         term_in[s][2] = MW'(ld_ff[0]) * MW'(edge_prod[s][2]);
         term_in[s][3] = MW'(lp_ff[2]) * MW'(edge_diff[s][0]);
         term_in[s][4] = MW'(ld_ff[1]) * MW'(edge_prod[s][0]);
         term_in[s][5] = MW'(ld_ff[2]) * MW'(edge_prod[s][1]);
         for (int j = 0; j < 3; j++) begin
            pair_in[s][j] = (MW+1)'(term_ff[s][2*j]) + (MW+1)'(term_ff[s][2*j+1]);
         end
         sum_in[s] = SW'(pair_ff[s][0]) + SW'(pair_ff[s][1]) + SW'(pair_ff[s][2]);
         zero_in[s] = (sum_in[s] == '0);
         neg_in[s]  = sum_in[s][SW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         p0_ff <= in_start;
         p1_ff <= in_end;
      end
      if (ready[1] && valid_ff[0]) begin
         lp_ff <= lp_in;
         ld_ff <= ld_in;
      end
      if (ready[2] && valid_ff[1]) begin
         term_ff <= term_in;
      end
      if (ready[3] && valid_ff[2]) begin
         pair_ff <= pair_in;
      end
      if (ready[4] && valid_ff[3]) begin
         zero_ff <= zero_in;
         neg_ff  <= neg_in;
      end
      if (ready[5] && valid_ff[4]) begin
         class_ff <= classify(zero_ff, neg_ff);
      end
   end

   assign out_valid          = valid_ff[NumStages-1];
   assign out_class          = class_ff;
   assign status.stage_valid = valid_ff;
   assign status.in_ready    = ready[0];

endmodule

>>> rtl/line_triangle_plucker_test.sv
// Line against triangle classifier using Plucker coordinates.
// The triangle's vertices are written through the csr_ channel: index 0, 1
// or 2 selects the vertex, csr_data holds it packed as z, y, x from the top
// down. csr_ready is always high and writes to index 3 are dropped. The
// edge coordinates are registered from the vertex registers.
// Each req_ transaction carries two points of a line; each rsp_ transaction
// carries one hit class: none, coplanar, interior, edge or vertex.
// A request passes through six register stages: input, line coordinates,
// products, pair sums, side signs and the output register. Throughput is
// one transaction per cycle while rsp_ready is high.
// When rsp_ready is low the stages fill in turn and req_ready falls only
// once every stage holds a transaction; nothing is lost or repeated.
// Reset clears all stage valid bits and the vertices to zero.
`include "line_triangle_plucker_test_macros.svh"

module line_triangle_plucker_test
   import plt_pkg::*;
#(
   parameter int COORD_WIDTH = DefaultCoordWidth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CsrIndexWidth-1:0]          csr_index,
   input  logic [3*COORD_WIDTH-1:0]          csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_WIDTH-1:0]     req_start_x,
   input  logic signed [COORD_WIDTH-1:0]     req_start_y,
   input  logic signed [COORD_WIDTH-1:0]     req_start_z,
   input  logic signed [COORD_WIDTH-1:0]     req_end_x,
   input  logic signed [COORD_WIDTH-1:0]     req_end_y,
   input  logic signed [COORD_WIDTH-1:0]     req_end_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [HitClassWidth-1:0]          rsp_hit_class
);

   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH + 1;

   logic [3*COORD_WIDTH-1:0]      vertex_ff [3];
   logic signed [PW-1:0]          edge_prod [NumSides][3];
   logic signed [DW-1:0]          edge_diff [NumSides][3];
   logic signed [COORD_WIDTH-1:0] start_pt [3];
   logic signed [COORD_WIDTH-1:0] end_pt [3];
   hit_class_type                 hit_class;
   pipe_status_type               status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff[0] <= '0;
         vertex_ff[1] <= '0;
         vertex_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            VERTEX_ZERO_IDX: vertex_ff[0] <= csr_data;
            VERTEX_ONE_IDX:  vertex_ff[1] <= csr_data;
            VERTEX_TWO_IDX:  vertex_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Edges (v1,v0), (v2,v1) and (v0,v2).
   plt_edge_coords #(.COORD_WIDTH(COORD_WIDTH)) u_edge_one (
      .clock      (clock),
      .vertex_a   (vertex_ff[1]),
      .vertex_b   (vertex_ff[0]),
      .prod_coord (edge_prod[0]),
      .diff_coord (edge_diff[0])
   );

   plt_edge_coords #(.COORD_WIDTH(COORD_WIDTH)) u_edge_two (
      .clock      (clock),
      .vertex_a   (vertex_ff[2]),
      .vertex_b   (vertex_ff[1]),
      .prod_coord (edge_prod[1]),
      .diff_coord (edge_diff[1])
   );

   plt_edge_coords #(.COORD_WIDTH(COORD_WIDTH)) u_edge_three (
      .clock      (clock),
      .vertex_a   (vertex_ff[0]),
      .vertex_b   (vertex_ff[2]),
      .prod_coord (edge_prod[2]),
      .diff_coord (edge_diff[2])
   );

   assign start_pt[0] = req_start_x;
   assign start_pt[1] = req_start_y;
   assign start_pt[2] = req_start_z;
   assign end_pt[0]   = req_end_x;
   assign end_pt[1]   = req_end_y;
   assign end_pt[2]   = req_end_z;

   plt_side_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_side_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_start  (start_pt),
      .in_end    (end_pt),
      .edge_prod (edge_prod),
      .edge_diff (edge_diff),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_class (hit_class),
      .status    (status)
   );

   assign req_ready     = status.in_ready;
   assign rsp_hit_class = hit_class;

   `PLT_ASSERT_SAME(a_full_stall_blocks, clock, reset, (&status.stage_valid) && !rsp_ready, !req_ready)
   `PLT_ASSERT_SAME(a_empty_accepts, clock, reset, !(|status.stage_valid), req_ready)
   `PLT_ASSERT_NEXT(a_drain_last, clock, reset, rsp_valid && rsp_ready && !status.stage_valid[NumStages-2], !rsp_valid)

endmodule
